### rtl/tsspc_pkg.sv
// ============================================================================
// tsspc_pkg
// Shared types and constants of the phase-angle triac controller with soft
// start: item structs, event codes, register indexes and widths.
// ============================================================================
package tsspc_pkg;

    // Widths and sizes
    localparam int AVG_DEPTH   = 32;
    localparam int AVG_SHIFT   = $clog2(AVG_DEPTH);
    localparam int SLOT_BITS   = (AVG_SHIFT > 0) ? AVG_SHIFT : 1;
    localparam int SAMPLE_BITS = 10;
    localparam int SUM_BITS    = SAMPLE_BITS + AVG_SHIFT;
    localparam int COUNT_BITS  = 16;
    localparam int ANGLE_BITS  = 11;
    localparam int HOLD_BITS   = 8;
    localparam int CFG_BITS    = 16;
    localparam int INDEX_BITS  = 3;

    // Constants
    localparam logic [HOLD_BITS-1:0]  HOLD_TICKS     = HOLD_BITS'(200);
    localparam logic [HOLD_BITS-1:0]  HOLD_MAX       = HOLD_BITS'(255);
    localparam logic [ANGLE_BITS-1:0] STOP_ANGLE     = ANGLE_BITS'(2000);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX      = {COUNT_BITS{1'b1}};
    localparam logic [SLOT_BITS-1:0]  SLOT_LAST      = SLOT_BITS'(AVG_DEPTH - 1);

    // Register reset values
    localparam logic [ANGLE_BITS-1:0] GATE_WIDTH_RST      = ANGLE_BITS'(200);
    localparam logic [ANGLE_BITS-1:0] ZERO_CROSS_BLANK_RST = ANGLE_BITS'(50);
    localparam logic [COUNT_BITS-1:0] LOSS_TIMEOUT_RST    = COUNT_BITS'(1500);
    localparam logic [ANGLE_BITS-1:0] FULL_ANGLE_RST      = ANGLE_BITS'(1000);
    localparam logic [ANGLE_BITS-1:0] ANGLE_FLOOR_RST     = ANGLE_BITS'(50);
    localparam logic [ANGLE_BITS-1:0] OFF_THRESHOLD_RST   = ANGLE_BITS'(990);
    localparam logic [ANGLE_BITS-1:0] RELAY_ON_BELOW_RST  = ANGLE_BITS'(60);
    localparam logic [ANGLE_BITS-1:0] RELAY_OFF_ABOVE_RST = ANGLE_BITS'(80);

    // Register indexes
    localparam logic [INDEX_BITS-1:0] REG_GATE_WIDTH       = 3'd0;
    localparam logic [INDEX_BITS-1:0] REG_ZERO_CROSS_BLANK = 3'd1;
    localparam logic [INDEX_BITS-1:0] REG_LOSS_TIMEOUT     = 3'd2;
    localparam logic [INDEX_BITS-1:0] REG_FULL_ANGLE       = 3'd3;
    localparam logic [INDEX_BITS-1:0] REG_ANGLE_FLOOR      = 3'd4;
    localparam logic [INDEX_BITS-1:0] REG_OFF_THRESHOLD    = 3'd5;
    localparam logic [INDEX_BITS-1:0] REG_RELAY_ON_BELOW   = 3'd6;
    localparam logic [INDEX_BITS-1:0] REG_RELAY_OFF_ABOVE  = 3'd7;

    // Event codes
    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_ZERO_CROSS = 2'd1,
        OP_CONTROL    = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]             op;
        logic [SAMPLE_BITS-1:0] power_sample;
        logic [SAMPLE_BITS-1:0] rate_sample;
        logic                   button_pressed;
    } in_item_t;

    typedef struct packed {
        logic                   gate_on;
        logic                   relay_on;
        logic                   running;
        logic                   ramping;
        logic [ANGLE_BITS-1:0]  pending_angle_out;
        logic [COUNT_BITS-1:0]  phase_position;
    } out_item_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] gate_width;
        logic [ANGLE_BITS-1:0] zero_cross_blank;
        logic [COUNT_BITS-1:0] loss_timeout;
        logic [ANGLE_BITS-1:0] full_angle;
        logic [ANGLE_BITS-1:0] angle_floor;
        logic [ANGLE_BITS-1:0] off_threshold;
        logic [ANGLE_BITS-1:0] relay_on_below;
        logic [ANGLE_BITS-1:0] relay_off_above;
    } cfg_t;

endpackage

### rtl/triac_soft_start_phase_control_top.sv
// ============================================================================
// triac_soft_start_phase_control_top
// Phase-angle triac controller with soft start: input and result registers,
// configuration registers and the event core.
// ============================================================================
// Usage:
//   item channel   : item_valid/item_ready carry one event (tick, zero crossing
//                    or control update) with its samples and button level.
//   result channel : result_valid/result_ready return one item per event with
//                    gate, relay, run and ramp flags, pending angle and phase.
//   cfg channel    : cfg_valid/cfg_ready write cfg_data into register cfg_index;
//                    always ready; the user must write only while no event is
//                    in flight, as the block does not enforce it.
//   An accepted event waits in the input register; its result is loaded
//   into the result register. Throughput: one event per cycle while results
//   are taken; the core handles the whole event in one pass between them.
//   When the receiver stalls, the result and input registers fill and
//   item_ready drops; it returns the cycle the result is taken.
//   Reset clears all counters, flags and averaging windows and loads the
//   register defaults; no clearing pass is needed.
// ============================================================================
module triac_soft_start_phase_control_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  tsspc_pkg::in_item_t              item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output tsspc_pkg::out_item_t             result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tsspc_pkg::INDEX_BITS-1:0] cfg_index,
    input  logic [tsspc_pkg::CFG_BITS-1:0]   cfg_data
);
    import tsspc_pkg::*;

    logic      item_valid_reg;
    in_item_t  item_reg;
    logic      result_valid_reg;
    logic      result_valid_next;
    out_item_t result_reg;
    out_item_t core_result;
    cfg_t      cfg_reg;
    logic      advance;

    // Handshake
    assign advance    = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;
    assign cfg_ready  = 1'b1;

    assign result_valid_next = advance ? 1'b1 : (result_ready ? 1'b0 : result_valid_reg);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    // Event core
    tsspc_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gate_width       <= GATE_WIDTH_RST;
            cfg_reg.zero_cross_blank <= ZERO_CROSS_BLANK_RST;
            cfg_reg.loss_timeout     <= LOSS_TIMEOUT_RST;
            cfg_reg.full_angle       <= FULL_ANGLE_RST;
            cfg_reg.angle_floor      <= ANGLE_FLOOR_RST;
            cfg_reg.off_threshold    <= OFF_THRESHOLD_RST;
            cfg_reg.relay_on_below   <= RELAY_ON_BELOW_RST;
            cfg_reg.relay_off_above  <= RELAY_OFF_ABOVE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GATE_WIDTH:       cfg_reg.gate_width       <= cfg_data[ANGLE_BITS-1:0];
                REG_ZERO_CROSS_BLANK: cfg_reg.zero_cross_blank <= cfg_data[ANGLE_BITS-1:0];
                REG_LOSS_TIMEOUT:     cfg_reg.loss_timeout     <= cfg_data[COUNT_BITS-1:0];
                REG_FULL_ANGLE:       cfg_reg.full_angle       <= cfg_data[ANGLE_BITS-1:0];
                REG_ANGLE_FLOOR:      cfg_reg.angle_floor      <= cfg_data[ANGLE_BITS-1:0];
                REG_OFF_THRESHOLD:    cfg_reg.off_threshold    <= cfg_data[ANGLE_BITS-1:0];
                REG_RELAY_ON_BELOW:   cfg_reg.relay_on_below   <= cfg_data[ANGLE_BITS-1:0];
                REG_RELAY_OFF_ABOVE:  cfg_reg.relay_off_above  <= cfg_data[ANGLE_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

### rtl/tsspc_avg.sv
// ============================================================================
// tsspc_avg
// Moving average over the last AVG_DEPTH samples: a window of registers,
// a running sum and a slot pointer. The average of the window including the
// new sample is presented in the same cycle.
// ============================================================================
module tsspc_avg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  logic [tsspc_pkg::SAMPLE_BITS-1:0] sample,
    output logic [tsspc_pkg::SAMPLE_BITS-1:0] avg
);
    import tsspc_pkg::*;

    logic [SAMPLE_BITS-1:0] window_reg [AVG_DEPTH];
    logic [SUM_BITS-1:0]    sum_reg;
    logic [SUM_BITS-1:0]    sum_next;
    logic [SLOT_BITS-1:0]   slot_reg;
    logic [SLOT_BITS-1:0]   slot_next;

    // Replace the oldest sample in the running sum
    assign sum_next  = sum_reg + SUM_BITS'(sample) - SUM_BITS'(window_reg[slot_reg]);
    assign slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
    assign avg       = sum_next[SUM_BITS-1 -: SAMPLE_BITS];

    // Window, sum and pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AVG_DEPTH; i++)
            begin
                window_reg[i] <= '0;
            end
            sum_reg  <= '0;
            slot_reg <= '0;
        end
        else if (step)
        begin
            window_reg[slot_reg] <= sample;
            sum_reg              <= sum_next;
            slot_reg             <= slot_next;
        end
    end

endmodule

### rtl/tsspc_core.sv
// ============================================================================
// tsspc_core
// Controller state and the single-pass event logic: tick, zero crossing and
// control update. The result shows the state after the event.
// ============================================================================
module tsspc_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  tsspc_pkg::in_item_t  item,
    input  tsspc_pkg::cfg_t      cfg,
    output tsspc_pkg::out_item_t result
);
    import tsspc_pkg::*;

    logic [COUNT_BITS-1:0]  phase_count_reg, phase_count_next;
    logic [COUNT_BITS-1:0]  ramp_timer_reg, ramp_timer_next;
    logic [ANGLE_BITS-1:0]  fire_angle_reg, fire_angle_next;
    logic [ANGLE_BITS-1:0]  pending_angle_reg, pending_angle_next;
    logic [ANGLE_BITS-1:0]  ramp_value_reg, ramp_value_next;
    logic                   run_flag_reg, run_flag_next;
    logic                   ramp_flag_reg, ramp_flag_next;
    logic                   gate_flag_reg, gate_flag_next;
    logic                   relay_flag_reg, relay_flag_next;
    logic [HOLD_BITS-1:0]   hold_count_reg, hold_count_next;

    logic                   ctrl_step;
    logic [SAMPLE_BITS-1:0] power_avg;
    logic [SAMPLE_BITS-1:0] rate_avg;
    logic signed [ANGLE_BITS:0] target_diff;
    logic [ANGLE_BITS-1:0]  target;
    logic [COUNT_BITS-1:0]  phase_inc;
    logic [COUNT_BITS-1:0]  timer_inc;
    logic [COUNT_BITS:0]    gate_end;

    assign ctrl_step = step && (item.op == OP_CONTROL);

    // Moving averages of the two potentiometers
    tsspc_avg u_rate_avg
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (ctrl_step),
        .sample (item.rate_sample),
        .avg    (rate_avg)
    );

    tsspc_avg u_power_avg
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (ctrl_step),
        .sample (item.power_sample),
        .avg    (power_avg)
    );

    // Target angle, clamped up to the angle floor
    assign target_diff = $signed({1'b0, cfg.full_angle})
                       - $signed((ANGLE_BITS+1)'(power_avg));
    assign target      = (target_diff < $signed({1'b0, cfg.angle_floor})) ?
                         cfg.angle_floor : target_diff[ANGLE_BITS-1:0];

    // Saturating counters and gate window end
    assign phase_inc = (phase_count_reg != COUNT_MAX) ? phase_count_reg + 1'b1
                                                      : phase_count_reg;
    assign timer_inc = (ramp_timer_reg != COUNT_MAX) ? ramp_timer_reg + 1'b1
                                                     : ramp_timer_reg;
    assign gate_end  = (COUNT_BITS+1)'(fire_angle_reg) + (COUNT_BITS+1)'(cfg.gate_width);

    // Event logic
    always_comb
    begin
        phase_count_next   = phase_count_reg;
        ramp_timer_next    = ramp_timer_reg;
        fire_angle_next    = fire_angle_reg;
        pending_angle_next = pending_angle_reg;
        ramp_value_next    = ramp_value_reg;
        run_flag_next      = run_flag_reg;
        ramp_flag_next     = ramp_flag_reg;
        gate_flag_next     = gate_flag_reg;
        relay_flag_next    = relay_flag_reg;
        hold_count_next    = hold_count_reg;

        if (step)
        begin
            case (item.op)
                OP_TICK:
                begin
                    phase_count_next = phase_inc;
                    ramp_timer_next  = timer_inc;
                    gate_flag_next   = run_flag_reg
                                    && (phase_inc >= COUNT_BITS'(fire_angle_reg))
                                    && ({1'b0, phase_inc} <= gate_end);
                end
                OP_ZERO_CROSS:
                begin
                    if (phase_count_reg > COUNT_BITS'(cfg.zero_cross_blank))
                    begin
                        gate_flag_next   = 1'b0;
                        phase_count_next = '0;
                        fire_angle_next  = pending_angle_reg;
                    end
                end
                OP_CONTROL:
                begin
                    // held button toggles run
                    if (item.button_pressed)
                    begin
                        if (hold_count_reg != HOLD_MAX)
                        begin
                            hold_count_next = hold_count_reg + 1'b1;
                        end
                        if (hold_count_reg == HOLD_TICKS)
                        begin
                            run_flag_next = !run_flag_reg;
                            if (!run_flag_reg)
                            begin
                                ramp_flag_next  = 1'b1;
                                ramp_value_next = cfg.full_angle;
                            end
                        end
                    end
                    else
                    begin
                        hold_count_next = '0;
                    end

                    // soft-start ramp step
                    if (ramp_flag_next && (ramp_timer_reg >= COUNT_BITS'(rate_avg)))
                    begin
                        if (ramp_value_next != '0)
                        begin
                            ramp_value_next = ramp_value_next - 1'b1;
                        end
                        if ((ramp_value_next == '0) || (ramp_value_next < target))
                        begin
                            ramp_flag_next = 1'b0;
                        end
                        ramp_timer_next = '0;
                    end

                    // mains loss
                    if (phase_count_reg > cfg.loss_timeout)
                    begin
                        run_flag_next    = 1'b0;
                        ramp_flag_next   = 1'b0;
                        phase_count_next = '0;
                    end

                    // pending angle and relay hysteresis
                    if (run_flag_next)
                    begin
                        if (target > cfg.off_threshold)
                        begin
                            pending_angle_next = STOP_ANGLE;
                        end
                        else if (ramp_flag_next)
                        begin
                            pending_angle_next = ramp_value_next;
                        end
                        else
                        begin
                            pending_angle_next = target;
                        end
                        if (pending_angle_next < cfg.relay_on_below)
                        begin
                            relay_flag_next = 1'b1;
                        end
                        if (pending_angle_next > cfg.relay_off_above)
                        begin
                            relay_flag_next = 1'b0;
                        end
                    end
                    else
                    begin
                        ramp_value_next    = '0;
                        pending_angle_next = STOP_ANGLE;
                        relay_flag_next    = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_count_reg   <= '0;
            ramp_timer_reg    <= '0;
            fire_angle_reg    <= '0;
            pending_angle_reg <= '0;
            ramp_value_reg    <= '0;
            run_flag_reg      <= 1'b0;
            ramp_flag_reg     <= 1'b0;
            gate_flag_reg     <= 1'b0;
            relay_flag_reg    <= 1'b0;
            hold_count_reg    <= '0;
        end
        else
        begin
            phase_count_reg   <= phase_count_next;
            ramp_timer_reg    <= ramp_timer_next;
            fire_angle_reg    <= fire_angle_next;
            pending_angle_reg <= pending_angle_next;
            ramp_value_reg    <= ramp_value_next;
            run_flag_reg      <= run_flag_next;
            ramp_flag_reg     <= ramp_flag_next;
            gate_flag_reg     <= gate_flag_next;
            relay_flag_reg    <= relay_flag_next;
            hold_count_reg    <= hold_count_next;
        end
    end

    // Result is the state after the event
    always_comb
    begin
        result.gate_on           = gate_flag_next;
        result.relay_on          = relay_flag_next;
        result.running           = run_flag_next;
        result.ramping           = ramp_flag_next;
        result.pending_angle_out = pending_angle_next;
        result.phase_position    = phase_count_next;
    end

endmodule

### tb/tsspc_status_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// tsspc_status_checker
// Watches the event, result and register channels of the triac controller.
// Keeps its own copy of the controller state and registers, works out the
// status item each accepted event must return and compares every returned
// item with the oldest one still awaited.
// ============================================================================
module tsspc_status_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    input  logic                             item_ready,
    input  tsspc_pkg::in_item_t              item,
    input  logic                             result_valid,
    input  logic                             result_ready,
    input  tsspc_pkg::out_item_t             result,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [tsspc_pkg::INDEX_BITS-1:0] cfg_index,
    input  logic [tsspc_pkg::CFG_BITS-1:0]   cfg_data,
    output int                               mismatch_count,
    output int                               awaited_count
);
    import tsspc_pkg::*;

    localparam int COUNT_TOP = (1 << COUNT_BITS) - 1;
    localparam int MAX_SHOWN = 10;

    // register copy
    int gate_width_r, blank_r, loss_r, full_r;
    int floor_r, off_r, relay_on_r, relay_off_r;

    // controller copy
    int phase, ramp_timer, fire, pending, ramp_val, hold;
    bit run, ramping, gate, relay;
    int power_win [AVG_DEPTH];
    int rate_win [AVG_DEPTH];
    int power_sum, rate_sum, power_slot, rate_slot;

    out_item_t awaited_status [$];
    int        result_index;
    int        mismatches;

    // Status after one event, state updated in place
    task automatic advance_controller(input in_item_t ev, output out_item_t status);
        int rate_avg;
        int power_avg;
        int target;
        bit toggle;
        case (ev.op)
            OP_TICK:
            begin
                if (phase < COUNT_TOP) phase++;
                if (ramp_timer < COUNT_TOP) ramp_timer++;
                gate = run && phase >= fire && phase <= fire + gate_width_r;
            end
            OP_ZERO_CROSS:
            begin
                // crossings inside the blanking time are ignored
                if (phase > blank_r)
                begin
                    gate  = 1'b0;
                    phase = 0;
                    fire  = pending;
                end
            end
            OP_CONTROL:
            begin
                // moving averages, rate first
                rate_sum = rate_sum + int'(ev.rate_sample) - rate_win[rate_slot];
                rate_win[rate_slot] = int'(ev.rate_sample);
                rate_slot = (rate_slot == AVG_DEPTH - 1) ? 0 : rate_slot + 1;
                rate_avg = rate_sum / AVG_DEPTH;
                power_sum = power_sum + int'(ev.power_sample) - power_win[power_slot];
                power_win[power_slot] = int'(ev.power_sample);
                power_slot = (power_slot == AVG_DEPTH - 1) ? 0 : power_slot + 1;
                power_avg = power_sum / AVG_DEPTH;

                target = full_r - power_avg;
                if (target < floor_r) target = floor_r;

                // held button toggles run once the hold count hits its mark
                if (ev.button_pressed)
                begin
                    toggle = (hold == int'(HOLD_TICKS));
                    if (hold < int'(HOLD_MAX)) hold++;
                    if (toggle)
                    begin
                        run = !run;
                        if (run)
                        begin
                            ramping  = 1'b1;
                            ramp_val = full_r;
                        end
                    end
                end
                else
                    hold = 0;

                // soft-start ramp step
                if (ramping && ramp_timer >= rate_avg)
                begin
                    if (ramp_val > 0) ramp_val--;
                    if (ramp_val == 0 || ramp_val < target) ramping = 1'b0;
                    ramp_timer = 0;
                end

                // no crossing in time: mains lost
                if (phase > loss_r)
                begin
                    run     = 1'b0;
                    ramping = 1'b0;
                    phase   = 0;
                end

                if (run)
                begin
                    if (target > off_r) pending = int'(STOP_ANGLE);
                    else if (ramping) pending = ramp_val;
                    else pending = target;
                    if (pending < relay_on_r) relay = 1'b1;
                    if (pending > relay_off_r) relay = 1'b0;
                end
                else
                begin
                    ramp_val = 0;
                    pending  = int'(STOP_ANGLE);
                    relay    = 1'b0;
                end
            end
            default: ;
        endcase
        status.gate_on           = gate;
        status.relay_on          = relay;
        status.running           = run;
        status.ramping           = ramping;
        status.pending_angle_out = ANGLE_BITS'(pending);
        status.phase_position    = COUNT_BITS'(phase);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        if (!rst_n)
        begin
            gate_width_r = GATE_WIDTH_RST;
            blank_r      = ZERO_CROSS_BLANK_RST;
            loss_r       = LOSS_TIMEOUT_RST;
            full_r       = FULL_ANGLE_RST;
            floor_r      = ANGLE_FLOOR_RST;
            off_r        = OFF_THRESHOLD_RST;
            relay_on_r   = RELAY_ON_BELOW_RST;
            relay_off_r  = RELAY_OFF_ABOVE_RST;
            phase = 0; ramp_timer = 0; fire = 0; pending = 0; ramp_val = 0; hold = 0;
            run = 1'b0; ramping = 1'b0; gate = 1'b0; relay = 1'b0;
            for (int k = 0; k < AVG_DEPTH; k++)
            begin
                power_win[k] = 0;
                rate_win[k]  = 0;
            end
            power_sum = 0; rate_sum = 0; power_slot = 0; rate_slot = 0;
            awaited_status.delete();
            result_index = 0;
            mismatches   = 0;
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GATE_WIDTH:       gate_width_r = cfg_data[ANGLE_BITS-1:0];
                    REG_ZERO_CROSS_BLANK: blank_r      = cfg_data[ANGLE_BITS-1:0];
                    REG_LOSS_TIMEOUT:     loss_r       = cfg_data;
                    REG_FULL_ANGLE:       full_r       = cfg_data[ANGLE_BITS-1:0];
                    REG_ANGLE_FLOOR:      floor_r      = cfg_data[ANGLE_BITS-1:0];
                    REG_OFF_THRESHOLD:    off_r        = cfg_data[ANGLE_BITS-1:0];
                    REG_RELAY_ON_BELOW:   relay_on_r   = cfg_data[ANGLE_BITS-1:0];
                    REG_RELAY_OFF_ABOVE:  relay_off_r  = cfg_data[ANGLE_BITS-1:0];
                    default: ;
                endcase
            end

            // returned status against the oldest awaited one
            if (result_valid && result_ready)
            begin
                if (awaited_status.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("result item %0d arrived with no event outstanding",
                                 result_index);
                end
                else
                begin
                    want = awaited_status.pop_front();
                    if (result !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display({"result item %0d mismatch: expected gate=%0b relay=%0b",
                                      " run=%0b ramp=%0b angle=%0d phase=%0d, got gate=%0b",
                                      " relay=%0b run=%0b ramp=%0b angle=%0d phase=%0d"},
                                     result_index, want.gate_on, want.relay_on,
                                     want.running, want.ramping, want.pending_angle_out,
                                     want.phase_position, result.gate_on, result.relay_on,
                                     result.running, result.ramping,
                                     result.pending_angle_out, result.phase_position);
                    end
                end
                result_index++;
            end

            // accepted event
            if (item_valid && item_ready)
            begin
                advance_controller(item, want);
                awaited_status.push_back(want);
            end
        end
        mismatch_count <= mismatches;
        awaited_count  <= awaited_status.size();
    end

endmodule

### tb/triac_soft_start_phase_control_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// triac_soft_start_phase_control_top_tb
// Drives the triac controller with mains-like event streams: ticks, zero
// crossings at a half period, control updates with a held start/stop button,
// plus noise and missing crossings. Runs several register settings, the
// extremes among them, with random gaps on both channels; a checker beside
// the block predicts and compares every status item.
// ============================================================================
module triac_soft_start_phase_control_top_tb;
    import tsspc_pkg::*;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int SAMPLE_TOP = (1 << SAMPLE_BITS) - 1;
    localparam int ANGLE_TOP  = (1 << ANGLE_BITS) - 1;
    localparam int COUNT_TOP  = (1 << COUNT_BITS) - 1;
    localparam int DRAIN_LIMIT = 100000;

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    in_item_t              item;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    out_item_t             result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [INDEX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]   cfg_data;
    int                    mismatch_count;
    int                    awaited_count;

    // no idling on either side while set
    bit calm;

    // mains stream state
    int ticks_since_cross, half_len, half_nom;
    int full_now, power_hi, rate_hi;
    bit button_level;
    int button_left;

    triac_soft_start_phase_control_top i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    tsspc_status_checker i_status_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item           (item),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result         (result),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stalls
    always @(negedge clk)
        result_ready <= calm || ($urandom_range(99) >= 6);

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // One event on the item channel; starts and ends at a falling edge
    task automatic send_event(input in_item_t ev);
        while (!calm && $urandom_range(99) < 6)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= ev;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_fields(input logic [1:0] op, input int p, input int r, input int b);
        in_item_t ev;
        ev.op             = op;
        ev.power_sample   = SAMPLE_BITS'(p);
        ev.rate_sample    = SAMPLE_BITS'(r);
        ev.button_pressed = 1'(b);
        send_event(ev);
    endtask

    task automatic write_reg(input logic [INDEX_BITS-1:0] idx, input logic [CFG_BITS-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // wait until every awaited status item has come back
    task automatic drain();
        int spent;
        spent = 0;
        item_valid <= 1'b0;
        while (awaited_count != 0 && spent < DRAIN_LIMIT)
        begin
            @(negedge clk);
            spent++;
        end
    endtask

    function automatic cfg_t make_cfg(input int gw, input int blank, input int loss,
                                      input int full, input int min_a, input int off,
                                      input int on_below, input int off_above);
        cfg_t s;
        s.gate_width       = ANGLE_BITS'(gw);
        s.zero_cross_blank = ANGLE_BITS'(blank);
        s.loss_timeout     = COUNT_BITS'(loss);
        s.full_angle       = ANGLE_BITS'(full);
        s.angle_floor      = ANGLE_BITS'(min_a);
        s.off_threshold    = ANGLE_BITS'(off);
        s.relay_on_below   = ANGLE_BITS'(on_below);
        s.relay_off_above  = ANGLE_BITS'(off_above);
        return s;
    endfunction

    // mostly below hi, now and then anywhere in range
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int hi);
        if ($urandom_range(31) == 0)
            return SAMPLE_BITS'($urandom_range(SAMPLE_TOP));
        return SAMPLE_BITS'($urandom_range(hi > SAMPLE_TOP ? SAMPLE_TOP : hi));
    endfunction

    // button alternates between releases and presses, long presses past the hold mark
    function automatic bit next_button();
        if (button_left == 0)
        begin
            button_level = !button_level;
            if (button_level)
                button_left = ($urandom_range(9) < 7) ? $urandom_range(270, 198)
                                                      : $urandom_range(20, 1);
            else
                button_left = $urandom_range(60, 3);
        end
        button_left--;
        return button_level;
    endfunction

    // next event of a mains-like stream
    task automatic gen_mains(output in_item_t ev);
        int pick;
        pick = $urandom_range(99);
        ev.op             = OP_TICK;
        ev.power_sample   = SAMPLE_BITS'($urandom_range(SAMPLE_TOP));
        ev.rate_sample    = SAMPLE_BITS'($urandom_range(SAMPLE_TOP));
        ev.button_pressed = 1'($urandom_range(1));
        if (pick < 4)
            ev.op = 2'($urandom_range(3));
        else if (ticks_since_cross >= half_len)
        begin
            ev.op = OP_ZERO_CROSS;
            ticks_since_cross = 0;
            // now and then a crossing goes missing long enough to lose mains
            half_len = ($urandom_range(14) == 0) ? 3 * half_nom + 10
                                                 : half_nom - 1 + $urandom_range(2);
            if ($urandom_range(5) == 0) power_hi = $urandom_range(2 * full_now + 4);
        end
        else if (pick < 52)
        begin
            ev.op = OP_TICK;
            ticks_since_cross++;
        end
        else
        begin
            ev.op             = OP_CONTROL;
            ev.power_sample   = pick_sample(power_hi);
            ev.rate_sample    = pick_sample(rate_hi);
            ev.button_pressed = next_button();
        end
    endtask

    // new register setting, then a random stretch of events
    task automatic run_phase(input cfg_t s, input int half, input int rate_max,
                             input int count);
        in_item_t ev;
        drain();
        write_reg(REG_GATE_WIDTH,       {5'($urandom_range(31)), s.gate_width});
        write_reg(REG_ZERO_CROSS_BLANK, {5'($urandom_range(31)), s.zero_cross_blank});
        write_reg(REG_LOSS_TIMEOUT,     s.loss_timeout);
        write_reg(REG_FULL_ANGLE,       {5'($urandom_range(31)), s.full_angle});
        write_reg(REG_ANGLE_FLOOR,      {5'($urandom_range(31)), s.angle_floor});
        write_reg(REG_OFF_THRESHOLD,    {5'($urandom_range(31)), s.off_threshold});
        write_reg(REG_RELAY_ON_BELOW,   {5'($urandom_range(31)), s.relay_on_below});
        write_reg(REG_RELAY_OFF_ABOVE,  {5'($urandom_range(31)), s.relay_off_above});
        cfg_valid <= 1'b0;
        half_nom          = half;
        half_len          = half;
        ticks_since_cross = 0;
        full_now          = s.full_angle;
        power_hi          = s.full_angle;
        rate_hi           = rate_max;
        repeat (count)
        begin
            gen_mains(ev);
            send_event(ev);
        end
    endtask

    initial
    begin
        item_valid   = 1'b0;
        item         = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        rst_n        = 1'b0;
        calm         = 1'b0;
        button_level = 1'b0;
        button_left  = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed events at reset settings
        send_fields(OP_RESERVED, SAMPLE_TOP, SAMPLE_TOP, 1);   // unknown op right after reset
        send_fields(OP_TICK, 0, 0, 0);
        send_fields(OP_ZERO_CROSS, SAMPLE_TOP, 0, 1);          // inside blanking
        send_fields(OP_CONTROL, SAMPLE_TOP, SAMPLE_TOP, 1);
        send_fields(OP_CONTROL, SAMPLE_TOP, 0, 1);
        send_fields(OP_CONTROL, 0, SAMPLE_TOP, 0);             // release clears hold
        send_fields(OP_CONTROL, 0, 0, 1);
        send_fields(OP_TICK, SAMPLE_TOP, SAMPLE_TOP, 1);
        send_fields(OP_TICK, 0, SAMPLE_TOP, 0);
        send_fields(OP_RESERVED, 0, 0, 0);
        send_fields(OP_ZERO_CROSS, 0, 0, 0);
        send_fields(OP_CONTROL, 0, 0, 0);

        // short half period, small angles
        run_phase(make_cfg(6, 4, 70, 40, 5, 36, 12, 16), 40, 6, 480);

        // all registers at zero
        run_phase(make_cfg(0, 0, 0, 0, 0, 0, 0, 0), 3, 2, 80);

        // all registers at their top
        run_phase(make_cfg(ANGLE_TOP, ANGLE_TOP, COUNT_TOP, ANGLE_TOP, ANGLE_TOP,
                           ANGLE_TOP, ANGLE_TOP, ANGLE_TOP), 2100, SAMPLE_TOP, 80);
        send_fields(OP_CONTROL, 0, SAMPLE_TOP, 1);
        send_fields(OP_CONTROL, SAMPLE_TOP, 0, 0);
        send_fields(OP_TICK, 0, 0, 0);
        send_fields(OP_ZERO_CROSS, 0, 0, 0);
        send_fields(OP_TICK, 0, 0, 0);

        // mid-size settings, no idling on either side
        calm = 1'b1;
        run_phase(make_cfg(20, 10, 300, 200, 20, 190, 30, 40), 200, 20, 350);
        calm = 1'b0;

        // random settings
        run_phase(make_cfg($urandom_range(ANGLE_TOP), $urandom_range(ANGLE_TOP),
                           $urandom_range(COUNT_TOP), $urandom_range(ANGLE_TOP),
                           $urandom_range(ANGLE_TOP), $urandom_range(ANGLE_TOP),
                           $urandom_range(ANGLE_TOP), $urandom_range(ANGLE_TOP)),
                  $urandom_range(60, 8), 8, 150);

        // wide gate, relay thresholds crossed over
        run_phase(make_cfg(ANGLE_TOP, 2, 50, 30, 3, 29, 20, 10), 30, 3, 400);

        drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && awaited_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
